// ===== design/met_pkg.sv =====
// Package for the minimum-eviction tally table: sizes, codes and payload types.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package met_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_W  = 16;
    localparam int AMT_W  = 24;
    localparam int TOT_W  = 40;
    localparam int HIT_W  = 24;
    localparam int RIDX_W = 4;
    localparam int SLOT_W = 4;
    localparam int LIVE_W = 5;
    localparam int CMP_W  = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_MATCH   = 3'd0,
        ACT_NEW     = 3'd1,
        ACT_MERGE   = 3'd2,
        ACT_REPLACE = 3'd3,
        ACT_NONE    = 3'd4
    } t_action;

    typedef struct packed {
        t_op                operation;
        logic [KEY_W-1:0]   source_key;
        logic [KEY_W-1:0]   attack_key;
        logic [AMT_W-1:0]   amount;
        logic [RIDX_W-1:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        t_action            action;
        logic               entry_valid;
        logic [KEY_W-1:0]   entry_source;
        logic [KEY_W-1:0]   entry_attack;
        logic [TOT_W-1:0]   entry_total;
        logic [HIT_W-1:0]   entry_hits;
        logic [LIVE_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]   src;
        logic [KEY_W-1:0]   atk;
        logic [TOT_W-1:0]   total;
        logic [HIT_W-1:0]   hits;
    } t_entry;

endpackage

// ===== design/met_req_if.sv =====
// Request channel of the tally table: valid, ready and one request payload.
// Depends on met_pkg.
`timescale 1ns / 1ps

interface met_req_if;
    logic          valid;
    logic          ready;
    met_pkg::t_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

// ===== design/met_rsp_if.sv =====
// Response channel of the tally table: valid, ready and one response payload.
// Depends on met_pkg.
`timescale 1ns / 1ps

interface met_rsp_if;
    logic          valid;
    logic          ready;
    met_pkg::t_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface

// ===== design/met_bump.sv =====
// Saturating accumulate of one table entry: adds an amount to the total and
// counts one hit. Depends on met_pkg.
`timescale 1ns / 1ps

module met_bump (
    input  met_pkg::t_entry                 i_entry,
    input  logic [met_pkg::AMT_W-1:0]       i_amount,
    output met_pkg::t_entry                 o_entry
);

    logic [met_pkg::TOT_W:0] w_sum;

    assign w_sum = {1'b0, i_entry.total} + (met_pkg::TOT_W + 1)'(i_amount);

    always_comb begin
        o_entry       = i_entry;
        o_entry.total = w_sum[met_pkg::TOT_W] ? {met_pkg::TOT_W{1'b1}}
                                              : w_sum[met_pkg::TOT_W-1:0];
        o_entry.hits  = (&i_entry.hits) ? i_entry.hits : i_entry.hits + 1'b1;
    end

endmodule

// ===== design/min_eviction_tally_table_top.sv =====
// Top level of the minimum-eviction tally table: entry memory, scan sequencer
// and response register. Depends on met_pkg, met_req_if, met_rsp_if, met_bump.
//
//   channel  dir  payload  handshake
//   i_req    in   t_req    valid/ready, taken when both high
//   o_rsp    out  t_rsp    valid/ready, taken when both high
//
// An add request scans the live entries through one registered memory read
// port and one key/total comparator, one entry a cycle, and stops early on a
// key match. i_req.ready stays low from acceptance until the response is
// loaded. Read, clear and unused requests skip the scan and go straight to
// the response step. Only one request is in flight; i_req.ready is high in
// the idle state. The response register frees the sequencer once filled, and
// a stalled o_rsp holds the final step. Reset clears the state, live count,
// scan index, flags and response valid, not the entry memory or payload.
`timescale 1ns / 1ps

module min_eviction_tally_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    met_req_if.sink     i_req,
    met_rsp_if.source   o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_RDOUT  = 5'b01000,
        S_MISC   = 5'b10000
    } t_state;

    t_state                          r_state;
    met_pkg::t_req                   r_req;
    logic [met_pkg::CNT_W-1:0]       r_live;
    logic [met_pkg::CNT_W-1:0]       r_idx;
    logic                            r_pend;
    logic [met_pkg::IDX_W-1:0]       r_pend_idx;
    logic                            r_found;
    logic [met_pkg::IDX_W-1:0]       r_sel_idx;
    met_pkg::t_entry                 r_sel;
    logic [met_pkg::IDX_W-1:0]       r_min_idx;
    met_pkg::t_entry                 r_min;
    met_pkg::t_entry                 r_rd_data;
    met_pkg::t_entry                 r_mem [met_pkg::TABLE_ENTRIES];
    logic                            r_out_valid;
    met_pkg::t_rsp                   r_rsp;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_rsp_load;
    logic                            w_issue;
    logic [met_pkg::IDX_W-1:0]       w_rd_addr;
    logic                            w_key_hit;
    logic                            w_less;
    met_pkg::t_entry                 w_base;
    met_pkg::t_entry                 w_bumped;
    met_pkg::t_entry                 w_fresh;
    met_pkg::t_entry                 w_upd;
    logic [met_pkg::IDX_W-1:0]       w_upd_slot;
    met_pkg::t_action                w_upd_act;
    logic [met_pkg::CNT_W-1:0]       w_upd_live;
    logic                            w_we;
    logic                            w_rd_valid;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_rsp_load  = ((r_state == S_UPDATE) || (r_state == S_RDOUT)
                       || (r_state == S_MISC)) && w_out_free;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.rsp   = r_rsp;

    assign w_issue   = (r_state == S_SCAN) && !r_found && (r_idx < r_live);
    assign w_rd_addr = (r_state == S_IDLE)  ? met_pkg::IDX_W'(i_req.req.read_index)
                     : (r_state == S_RDOUT) ? met_pkg::IDX_W'(r_req.read_index)
                                            : r_idx[met_pkg::IDX_W-1:0];

    assign w_key_hit = (r_rd_data.src == r_req.source_key)
                    && (r_rd_data.atk == r_req.attack_key);
    assign w_less    = (r_pend_idx == '0) || (r_rd_data.total < r_min.total);

    assign w_base  = r_found ? r_sel : r_min;
    assign w_fresh = '{src: r_req.source_key, atk: r_req.attack_key,
                       total: met_pkg::TOT_W'(r_req.amount),
                       hits: met_pkg::HIT_W'(1)};

    met_bump u_bump (
        .i_entry  (w_base),
        .i_amount (r_req.amount),
        .o_entry  (w_bumped)
    );

    always_comb begin
        w_upd_live = r_live;
        if (r_found) begin
            w_upd_act  = met_pkg::ACT_MATCH;
            w_upd_slot = r_sel_idx;
            w_upd      = w_bumped;
        end else if (r_live < met_pkg::CNT_W'(met_pkg::TABLE_ENTRIES)) begin
            w_upd_act  = met_pkg::ACT_NEW;
            w_upd_slot = r_live[met_pkg::IDX_W-1:0];
            w_upd      = w_fresh;
            w_upd_live = r_live + 1'b1;
        end else if (r_min.total >= met_pkg::TOT_W'(r_req.amount)) begin
            w_upd_act  = met_pkg::ACT_MERGE;
            w_upd_slot = r_min_idx;
            w_upd      = w_bumped;
        end else begin
            w_upd_act  = met_pkg::ACT_REPLACE;
            w_upd_slot = r_min_idx;
            w_upd      = w_fresh;
        end
    end

    assign w_we       = (r_state == S_UPDATE) && w_out_free;
    assign w_rd_valid = met_pkg::CMP_W'(r_req.read_index) < met_pkg::CMP_W'(r_live);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_upd_slot] <= w_upd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_req.req;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        case (i_req.req.operation)
                            met_pkg::OP_ADD:  r_state <= S_SCAN;
                            met_pkg::OP_READ: r_state <= S_RDOUT;
                            default:          r_state <= S_MISC;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx      <= r_idx + 1'b1;
                        r_pend_idx <= r_idx[met_pkg::IDX_W-1:0];
                    end
                    if (r_pend && !r_found) begin
                        if (w_key_hit) begin
                            r_found   <= 1'b1;
                            r_sel_idx <= r_pend_idx;
                            r_sel     <= r_rd_data;
                        end
                        if (w_less) begin
                            r_min_idx <= r_pend_idx;
                            r_min     <= r_rd_data;
                        end
                    end
                    if (!w_issue && !r_pend) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_out_free) begin
                        r_live                  <= w_upd_live;
                        r_rsp.slot              <= met_pkg::SLOT_W'(w_upd_slot);
                        r_rsp.action            <= w_upd_act;
                        r_rsp.entry_valid       <= 1'b1;
                        r_rsp.entry_source      <= w_upd.src;
                        r_rsp.entry_attack      <= w_upd.atk;
                        r_rsp.entry_total       <= w_upd.total;
                        r_rsp.entry_hits        <= w_upd.hits;
                        r_rsp.entry_count       <= met_pkg::LIVE_W'(w_upd_live);
                        r_state                 <= S_IDLE;
                    end
                end
                S_RDOUT: begin
                    if (w_out_free) begin
                        r_rsp.slot              <= met_pkg::SLOT_W'(r_req.read_index);
                        r_rsp.action            <= met_pkg::ACT_NONE;
                        r_rsp.entry_valid       <= w_rd_valid;
                        r_rsp.entry_source      <= w_rd_valid ? r_rd_data.src : '0;
                        r_rsp.entry_attack      <= w_rd_valid ? r_rd_data.atk : '0;
                        r_rsp.entry_total       <= w_rd_valid ? r_rd_data.total : '0;
                        r_rsp.entry_hits        <= w_rd_valid ? r_rd_data.hits : '0;
                        r_rsp.entry_count       <= met_pkg::LIVE_W'(r_live);
                        r_state                 <= S_IDLE;
                    end
                end
                S_MISC: begin
                    if (w_out_free) begin
                        if (r_req.operation == met_pkg::OP_CLEAR) begin
                            r_live <= '0;
                        end
                        r_rsp.slot              <= '0;
                        r_rsp.action            <= met_pkg::ACT_NONE;
                        r_rsp.entry_valid       <= 1'b0;
                        r_rsp.entry_source      <= '0;
                        r_rsp.entry_attack      <= '0;
                        r_rsp.entry_total       <= '0;
                        r_rsp.entry_hits        <= '0;
                        r_rsp.entry_count       <= (r_req.operation == met_pkg::OP_CLEAR)
                                                   ? '0 : met_pkg::LIVE_W'(r_live);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= met_pkg::CNT_W'(met_pkg::TABLE_ENTRIES))
        else $error("live count beyond table size");

    a_pend_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (met_pkg::CNT_W'(r_pend_idx) < r_live))
        else $error("scan compare on an entry that is not live");

    a_update_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_rsp.action == met_pkg::ACT_MATCH
                      || r_rsp.action == met_pkg::ACT_NEW
                      || r_rsp.action == met_pkg::ACT_MERGE
                      || r_rsp.action == met_pkg::ACT_REPLACE))
        |-> (r_rsp.entry_valid && (r_rsp.entry_hits != '0)
             && (r_rsp.entry_count != '0)))
        else $error("update response without a live counted entry");

endmodule

// ===== sim/tb_min_eviction_tally_table_top.sv =====
// Testbench for min_eviction_tally_table_top: a queue-fed request driver, a response
// monitor and a tally-table predictor that scores every response in order.
// Depends on met_pkg, met_req_if, met_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_min_eviction_tally_table_top;
    import met_pkg::*;

    localparam int POOL_PAIRS       = 24;
    localparam int RANDOM_PER_PHASE = 103;
    localparam int REPEAT_ADDS      = 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 25;

    logic i_clk;
    logic i_rst_n;

    met_req_if req_ch ();
    met_rsp_if rsp_ch ();

    min_eviction_tally_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_req               pending_reqs[$];
    t_rsp               expected_rsps[$];
    logic               req_took;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 mismatches;
    int                 quiet_cycles;

    logic [KEY_W-1:0]   tally_src   [TABLE_ENTRIES];
    logic [KEY_W-1:0]   tally_atk   [TABLE_ENTRIES];
    logic [TOT_W-1:0]   tally_total [TABLE_ENTRIES];
    logic [HIT_W-1:0]   tally_hits  [TABLE_ENTRIES];
    int                 tally_live;

    logic [KEY_W-1:0]   pool_src [POOL_PAIRS];
    logic [KEY_W-1:0]   pool_atk [POOL_PAIRS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void tally_bump(int s, logic [AMT_W-1:0] amt);
        logic [TOT_W:0] sum;
        sum = {1'b0, tally_total[s]} + amt;
        tally_total[s] = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
        if (tally_hits[s] != {HIT_W{1'b1}})
            tally_hits[s] = tally_hits[s] + 1'b1;
    endfunction

    function automatic t_rsp tally_step(t_req r);
        t_rsp o;
        int   slot;
        int   k;
        o        = '0;
        o.action = ACT_NONE;
        slot     = -1;
        case (r.operation)
            OP_ADD: begin
                for (k = 0; k < tally_live; k++)
                    if (slot < 0 && tally_src[k] == r.source_key && tally_atk[k] == r.attack_key)
                        slot = k;
                if (slot >= 0) begin
                    tally_bump(slot, r.amount);
                    o.action = ACT_MATCH;
                end else if (tally_live < TABLE_ENTRIES) begin
                    slot = tally_live;
                    tally_live++;
                    o.action = ACT_NEW;
                end else begin
                    slot = 0;
                    for (k = 1; k < tally_live; k++)
                        if (tally_total[k] < tally_total[slot])
                            slot = k;
                    if (tally_total[slot] >= r.amount) begin
                        tally_bump(slot, r.amount);
                        o.action = ACT_MERGE;
                    end else begin
                        o.action = ACT_REPLACE;
                    end
                end
                if (o.action == ACT_NEW || o.action == ACT_REPLACE) begin
                    tally_src[slot]   = r.source_key;
                    tally_atk[slot]   = r.attack_key;
                    tally_total[slot] = TOT_W'(r.amount);
                    tally_hits[slot]  = HIT_W'(1);
                end
            end
            OP_CLEAR: begin
                tally_live = 0;
            end
            OP_READ: begin
                o.slot = r.read_index;
                if (r.read_index < tally_live)
                    slot = r.read_index;
            end
            default: begin
            end
        endcase
        if (slot >= 0) begin
            o.slot         = SLOT_W'(slot);
            o.entry_valid  = 1'b1;
            o.entry_source = tally_src[slot];
            o.entry_attack = tally_atk[slot];
            o.entry_total  = tally_total[slot];
            o.entry_hits   = tally_hits[slot];
        end
        o.entry_count = LIVE_W'(tally_live);
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic void queue_req(t_op op, logic [KEY_W-1:0] src, logic [KEY_W-1:0] atk,
                                      logic [AMT_W-1:0] amt, logic [RIDX_W-1:0] ridx);
        t_req r;
        r.operation  = op;
        r.source_key = src;
        r.attack_key = atk;
        r.amount     = amt;
        r.read_index = ridx;
        pending_reqs.push_back(r);
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   pick;
        int   p;
        r.source_key = KEY_W'($urandom);
        r.attack_key = KEY_W'($urandom);
        r.read_index = RIDX_W'($urandom_range(TABLE_ENTRIES - 1));
        pick = $urandom_range(99);
        if (pick < 76)
            r.operation = OP_ADD;
        else if (pick < 91)
            r.operation = OP_READ;
        else if (pick < 94)
            r.operation = OP_CLEAR;
        else
            r.operation = OP_NOP;
        if (r.operation == OP_ADD && $urandom_range(9) != 0) begin
            p = $urandom_range(POOL_PAIRS - 1);
            r.source_key = pool_src[p];
            r.attack_key = pool_atk[p];
        end
        case ($urandom_range(2))
            0:       r.amount = AMT_W'($urandom_range(255));
            1:       r.amount = AMT_W'($urandom_range(65535));
            default: r.amount = AMT_W'($urandom_range(24'hFFFFFF));
        endcase
        return r;
    endfunction

    // request driver: change inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.req   <= '0;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (!req_ch.valid || req_took) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.req   <= pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_rsp want;
        t_rsp got;
        req_took <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.rsp;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding: slot 0x%0h action 0x%0h",
                           got.slot, got.action);
                    mismatches++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("slot",         64'(want.slot),         64'(got.slot));
                    check_field("action",       64'(want.action),       64'(got.action));
                    check_field("entry_valid",  64'(want.entry_valid),  64'(got.entry_valid));
                    check_field("entry_source", 64'(want.entry_source), 64'(got.entry_source));
                    check_field("entry_attack", 64'(want.entry_attack), 64'(got.entry_attack));
                    check_field("entry_total",  64'(want.entry_total),  64'(got.entry_total));
                    check_field("entry_hits",   64'(want.entry_hits),   64'(got.entry_hits));
                    check_field("entry_count",  64'(want.entry_count),  64'(got.entry_count));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(tally_step(req_ch.req));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int k;
        int idle_send [4];
        int idle_recv [4];
        idle_send = '{0, 58, 0, 12};
        idle_recv = '{0, 0, 58, 12};
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.req     = '0;
        rsp_ch.ready   = 1'b0;
        req_took       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        tally_live     = 0;
        for (k = 0; k < POOL_PAIRS; k++) begin
            pool_src[k] = (k % 2 == 1) ? pool_src[k-1] : KEY_W'($urandom);
            pool_atk[k] = KEY_W'($urandom);
        end

        // empty table, unused code, extremes of keys and amount
        queue_req(OP_READ, '0, '0, '0, '0);
        queue_req(OP_NOP, '1, '1, '1, '1);
        queue_req(OP_ADD, '0, '0, '0, '0);
        queue_req(OP_ADD, '1, '1, '1, '0);
        queue_req(OP_ADD, '0, '0, AMT_W'(5), '0);
        queue_req(OP_READ, '0, '0, '0, '1);
        queue_req(OP_READ, '0, '0, '0, RIDX_W'(1));
        for (k = 2; k < TABLE_ENTRIES; k++)
            queue_req(OP_ADD, KEY_W'(16'h0100 + k), KEY_W'(16'hA5A5 ^ k), AMT_W'(100), '0);
        // full table: merge, replace, then a tie among equal minima
        queue_req(OP_ADD, 16'h7001, 16'h7001, AMT_W'(3), '0);
        queue_req(OP_ADD, 16'h7002, 16'h7002, AMT_W'(50), '0);
        queue_req(OP_ADD, 16'h7003, 16'h7003, AMT_W'(200), '0);
        queue_req(OP_ADD, 16'h7004, 16'h7004, AMT_W'(100), '0);
        queue_req(OP_READ, '0, '0, '0, '1);
        queue_req(OP_CLEAR, '0, '0, '0, '0);
        queue_req(OP_READ, '0, '0, '0, '0);
        // repeat the largest amount on one entry
        for (k = 0; k < REPEAT_ADDS; k++)
            queue_req(OP_ADD, 16'h5A5A, 16'hC3C3, '1, '0);
        queue_req(OP_READ, '0, '0, '0, '0);
        queue_req(OP_CLEAR, '0, '0, '0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < 4; p++) begin
            while (pending_reqs.size() != 0)
                @(posedge i_clk);
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                pending_reqs.push_back(random_req());
        end

        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
